// ===== sv/mfgd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the mesh face geodesic distance engine.
package mfgd_pkg;

  localparam int MAX_FACES       = 1024;
  localparam int FACE_W          = $clog2(MAX_FACES);
  localparam int CNT_W           = FACE_W + 1;
  localparam int MAX_NEIGHBORS   = 3;
  localparam int NBR_IDX_W       = $clog2(MAX_NEIGHBORS);
  localparam int FRAC_BITS       = 16;
  localparam int NORM_LIMIT_BITS = 14;
  localparam int DIST_W          = 32;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  localparam logic CFG_EDGE_SCALE = 1'b0;
  localparam logic CFG_FACE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         face_id;
    logic signed [31:0] bary_x;
    logic signed [31:0] bary_y;
    logic signed [31:0] bary_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic [9:0]         nbr_a;
    logic [9:0]         nbr_b;
    logic [9:0]         nbr_c;
    logic [1:0]         nbr_count;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  out_face;
    logic [31:0] distance;
    logic [10:0] reached_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] bary_x;
    logic [31:0] bary_y;
    logic [31:0] bary_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } geom_t;

  typedef struct packed {
    logic              valid;
    logic [FACE_W-1:0] id;
  } nbr_t;

  typedef struct packed {
    geom_t                         geom;
    nbr_t [MAX_NEIGHBORS-1:0]      nbr;
  } face_rec_t;

  typedef struct packed {
    logic              visited;
    logic [DIST_W-1:0] path;
  } dist_ent_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] weight;
  } wt_rsp_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_INF : s[DIST_W-1:0];
  endfunction

endpackage

// ===== sv/mfgd_weight.sv =====
`timescale 1ns / 1ps
// Edge weight unit: barycenter distance plus scaled sine of the dihedral angle.
module mfgd_weight (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mfgd_pkg::geom_t   u_i,
  input  mfgd_pkg::geom_t   v_i,
  input  logic [31:0]       edge_scale_i,
  output mfgd_pkg::wt_rsp_t rsp_o
);

  typedef enum logic [7:0] {
    W_IDLE = 8'b0000_0001,
    W_RED  = 8'b0000_0010,
    W_MUL  = 8'b0000_0100,
    W_ESQ  = 8'b0000_1000,
    W_DIV  = 8'b0001_0000,
    W_DSQ  = 8'b0010_0000,
    W_SCL  = 8'b0100_0000,
    W_FIN  = 8'b1000_0000
  } wstate_e;

  localparam int NL = mfgd_pkg::NORM_LIMIT_BITS;
  localparam int FB = mfgd_pkg::FRAC_BITS;
  localparam logic [4:0] MUL_LAST  = 5'd20;
  localparam logic [4:0] ITER_LAST = 5'd31;

  wstate_e state_q, state_d;
  logic [4:0] step_q, step_d;

  logic [2:0][31:0] ua, ub;
  logic [2:0][31:0] ma_q, mb_q;
  logic signed [32:0] ra [3];
  logic signed [32:0] rb [3];
  logic big_a, big_b;

  logic signed [32:0] dx, dy, dz;
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod_q;
  logic signed [32:0] tmp_q;
  logic signed [32:0] cr_q [3];
  logic [66:0] esum_q;
  logic [61:0] csum_q, pp_q, rem_q;
  logic [31:0] na_q, nb_q;
  logic [32:0] q_q, q_n;
  logic [62:0] rem2;
  logic        div_ge;
  logic [63:0] sx_q, sr_q, sb_q, sq_t, sx_n, sr_n, sb_n;
  logic [31:0] euc_q, dih;
  logic        zd_q, csum_ge;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign ua = {u_i.norm_z, u_i.norm_y, u_i.norm_x};
  assign ub = {v_i.norm_z, v_i.norm_y, v_i.norm_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra[i] = ua[i][31] ? -$signed({19'b0, ma_q[i][NL-1:0]})
                        : $signed({19'b0, ma_q[i][NL-1:0]});
      rb[i] = ub[i][31] ? -$signed({19'b0, mb_q[i][NL-1:0]})
                        : $signed({19'b0, mb_q[i][NL-1:0]});
    end
  end

  assign big_a = |{ma_q[0][31:NL], ma_q[1][31:NL], ma_q[2][31:NL]};
  assign big_b = |{mb_q[0][31:NL], mb_q[1][31:NL], mb_q[2][31:NL]};

  assign dx = $signed({u_i.bary_x[31], u_i.bary_x}) - $signed({v_i.bary_x[31], v_i.bary_x});
  assign dy = $signed({u_i.bary_y[31], u_i.bary_y}) - $signed({v_i.bary_y[31], v_i.bary_y});
  assign dz = $signed({u_i.bary_z[31], u_i.bary_z}) - $signed({v_i.bary_z[31], v_i.bary_z});

  // Multiply schedule: each step issues one product and folds in the one before.
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_q)
      W_MUL: begin
        case (step_q)
          5'd0:  begin opa = dx;       opb = dx;       end
          5'd1:  begin opa = dy;       opb = dy;       end
          5'd2:  begin opa = dz;       opb = dz;       end
          5'd3:  begin opa = ra[1];    opb = rb[2];    end
          5'd4:  begin opa = ra[2];    opb = rb[1];    end
          5'd5:  begin opa = ra[2];    opb = rb[0];    end
          5'd6:  begin opa = ra[0];    opb = rb[2];    end
          5'd7:  begin opa = ra[0];    opb = rb[1];    end
          5'd8:  begin opa = ra[1];    opb = rb[0];    end
          5'd9:  begin opa = cr_q[0];  opb = cr_q[0];  end
          5'd10: begin opa = cr_q[1];  opb = cr_q[1];  end
          5'd11: begin opa = cr_q[2];  opb = cr_q[2];  end
          5'd12: begin opa = ra[0];    opb = ra[0];    end
          5'd13: begin opa = ra[1];    opb = ra[1];    end
          5'd14: begin opa = ra[2];    opb = ra[2];    end
          5'd15: begin opa = rb[0];    opb = rb[0];    end
          5'd16: begin opa = rb[1];    opb = rb[1];    end
          5'd17: begin opa = rb[2];    opb = rb[2];    end
          5'd19: begin
            opa = $signed({1'b0, na_q});
            opb = $signed({1'b0, nb_q});
          end
          default: ;
        endcase
      end
      W_SCL: begin
        opa = $signed({16'b0, sr_q[16:0]});
        opb = $signed({1'b0, edge_scale_i});
      end
      default: ;
    endcase
  end

  assign sq_t = sr_q + sb_q;
  always_comb begin
    if (sx_q >= sq_t) begin
      sx_n = sx_q - sq_t;
      sr_n = (sr_q >> 1) + sb_q;
    end else begin
      sx_n = sx_q;
      sr_n = sr_q >> 1;
    end
    sb_n = sb_q >> 2;
  end

  assign rem2    = {rem_q, 1'b0};
  assign div_ge  = rem2 >= {1'b0, pp_q};
  assign q_n     = {q_q[31:0], div_ge};
  assign csum_ge = csum_q >= pp_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      W_IDLE: if (start_i) state_d = W_RED;
      W_RED: begin
        if (!big_a && !big_b) begin
          state_d = W_MUL;
          step_d  = '0;
        end
      end
      W_MUL: begin
        step_d = step_q + 5'd1;
        if (step_q == MUL_LAST) begin
          state_d = W_ESQ;
          step_d  = '0;
        end
      end
      W_ESQ: begin
        step_d = step_q + 5'd1;
        if (step_q == ITER_LAST) state_d = (pp_q == '0) ? W_FIN : W_DIV;
      end
      W_DIV: begin
        step_d = step_q + 5'd1;
        if (step_q == ITER_LAST) state_d = W_DSQ;
      end
      W_DSQ: begin
        step_d = step_q + 5'd1;
        if (step_q == ITER_LAST) state_d = W_SCL;
      end
      W_SCL:   state_d = W_FIN;
      W_FIN:   state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            ma_q[i] <= mag(ua[i]);
            mb_q[i] <= mag(ub[i]);
          end
          esum_q <= '0;
          csum_q <= '0;
          na_q   <= '0;
          nb_q   <= '0;
        end
      end
      W_RED: begin
        for (int i = 0; i < 3; i++) begin
          if (big_a) ma_q[i] <= ma_q[i] >> 1;
          if (big_b) mb_q[i] <= mb_q[i] >> 1;
        end
      end
      W_MUL: begin
        case (step_q)
          5'd1, 5'd2, 5'd3:    esum_q <= esum_q + {2'b0, prod_q[64:0]};
          5'd4, 5'd6, 5'd8:    tmp_q <= prod_q[32:0];
          5'd5:                cr_q[0] <= tmp_q - prod_q[32:0];
          5'd7:                cr_q[1] <= tmp_q - prod_q[32:0];
          5'd9:                cr_q[2] <= tmp_q - prod_q[32:0];
          5'd10, 5'd11, 5'd12: csum_q <= csum_q + prod_q[61:0];
          5'd13, 5'd14, 5'd15: na_q <= na_q + prod_q[31:0];
          5'd16, 5'd17, 5'd18: nb_q <= nb_q + prod_q[31:0];
          5'd20: begin
            pp_q <= prod_q[61:0];
            sx_q <= esum_q[63:0];
            sr_q <= '0;
            sb_q <= {2'b01, 62'b0};
          end
          default: ;
        endcase
      end
      W_ESQ: begin
        sx_q <= sx_n;
        sr_q <= sr_n;
        sb_q <= sb_n;
        if (step_q == ITER_LAST) begin
          euc_q <= (esum_q[66:64] != 3'b0) ? mfgd_pkg::DIST_INF : sr_n[31:0];
          zd_q  <= (pp_q == '0);
          q_q   <= {32'b0, csum_ge};
          rem_q <= csum_ge ? (csum_q - pp_q) : csum_q;
        end
      end
      W_DIV: begin
        q_q   <= q_n;
        rem_q <= div_ge ? (rem2[61:0] - pp_q) : rem2[61:0];
        if (step_q == ITER_LAST) begin
          sx_q <= {31'b0, q_n};
          sr_q <= '0;
          sb_q <= {2'b01, 62'b0};
        end
      end
      W_DSQ: begin
        sx_q <= sx_n;
        sr_q <= sr_n;
        sb_q <= sb_n;
      end
      default: ;
    endcase
  end

  assign dih = zd_q ? 32'd0 : prod_q[FB+31:FB];
  assign rsp_o.done   = (state_q == W_FIN);
  assign rsp_o.weight = mfgd_pkg::sat_add(euc_q, dih);

endmodule

// ===== sv/mesh_face_geodesic_dijkstra.sv =====
`timescale 1ns / 1ps
// Top level of the mesh face geodesic distance engine.
// Face records and the distance table live in two single-port-write,
// registered-read memories. A load or an unused command is answered straight
// from idle, a read through S_READ. A run first sweeps all 1024 distance
// entries, then for each reached face scans the table once (one entry per cycle
// through the distance memory read port), visits the winner in S_VISIT and
// S_UREC, steps over each unused neighbor slot in S_NBR, and evaluates each
// valid neighbor with the sequential weight unit (normal reduction, one shared
// 33x33 multiplier, a bit-serial square root and divider), which skips the
// divider and the second root when either normal is zero. After reset the
// distance table is swept once with the input held off; configuration writes
// are taken at any time.
module mesh_face_geodesic_dijkstra (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfgd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfgd_pkg::out_item_t out_data_o
);

  localparam int FW = mfgd_pkg::FACE_W;
  localparam int CW = mfgd_pkg::CNT_W;
  localparam int NN = mfgd_pkg::MAX_NEIGHBORS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_CLEAR = 12'b0000_0000_0010,
    S_START = 12'b0000_0000_0100,
    S_SCAN  = 12'b0000_0000_1000,
    S_SCEND = 12'b0000_0001_0000,
    S_VISIT = 12'b0000_0010_0000,
    S_UREC  = 12'b0000_0100_0000,
    S_NBR   = 12'b0000_1000_0000,
    S_VREC  = 12'b0001_0000_0000,
    S_WGO   = 12'b0010_0000_0000,
    S_WAIT  = 12'b0100_0000_0000,
    S_READ  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] edge_scale_q;
  logic [CW-1:0] face_count_q, fc, fc_m1;

  mfgd_pkg::face_rec_t face_mem [mfgd_pkg::MAX_FACES];
  mfgd_pkg::dist_ent_t dist_mem [mfgd_pkg::MAX_FACES];
  mfgd_pkg::face_rec_t face_rdata_q, fm_wdata;
  mfgd_pkg::dist_ent_t dist_rdata_q, dm_wdata;
  logic          fm_we, dm_we;
  logic [FW-1:0] fm_raddr, dm_raddr, dm_waddr;

  logic [FW-1:0] idx_q, idx_d, ridx_q, cur_q, cur_d, start_q, start_d;
  logic [FW-1:0] nb_q, nb_d, face_id_q, face_id_d;
  logic          rv_q, rv_d, found_q, found_d, run_q, run_d;
  logic [31:0]   best_q, best_d;
  logic [CW-1:0] reached_q, reached_d;
  logic [mfgd_pkg::NBR_IDX_W-1:0] k_q, k_d;
  mfgd_pkg::geom_t u_geom_q, v_geom_q;
  mfgd_pkg::nbr_t [NN-1:0] u_nbr_q;
  mfgd_pkg::dist_ent_t dnb_q;
  mfgd_pkg::nbr_t cur_nbr;

  logic          scan_cand, found_n;
  logic [31:0]   best_n, nd;
  logic [FW-1:0] cur_n;

  logic          wt_start;
  mfgd_pkg::wt_rsp_t wt_rsp;

  mfgd_pkg::out_item_t out_q, out_d;
  logic          out_valid_q, out_set;
  logic          accept, id_bad, last_nbr;

  assign fc = (face_count_q == '0 || face_count_q > CW'(mfgd_pkg::MAX_FACES))
              ? CW'(mfgd_pkg::MAX_FACES) : face_count_q;
  assign fc_m1 = fc - CW'(1);

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign id_bad      = ({1'b0, in_data_i.face_id} >= fc);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_scale_q <= '0;
      face_count_q <= CW'(mfgd_pkg::MAX_FACES);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mfgd_pkg::CFG_EDGE_SCALE: edge_scale_q <= cfg_wdata_i;
        mfgd_pkg::CFG_FACE_COUNT: face_count_q <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Running minimum over the scan, lowest index wins on ties.
  assign scan_cand = rv_q && !dist_rdata_q.visited
                     && (dist_rdata_q.path != mfgd_pkg::DIST_INF)
                     && (!found_q || dist_rdata_q.path < best_q);
  assign found_n = found_q || scan_cand;
  assign best_n  = scan_cand ? dist_rdata_q.path : best_q;
  assign cur_n   = scan_cand ? ridx_q : cur_q;

  assign cur_nbr  = u_nbr_q[k_q];
  assign last_nbr = (k_q == mfgd_pkg::NBR_IDX_W'(NN - 1));
  assign nd       = mfgd_pkg::sat_add(best_q, wt_rsp.weight);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rv_d      = 1'b0;
    found_d   = found_q;
    best_d    = best_q;
    cur_d     = cur_q;
    start_d   = start_q;
    run_d     = run_q;
    reached_d = reached_q;
    k_d       = k_q;
    nb_d      = nb_q;
    face_id_d = face_id_q;
    fm_we     = 1'b0;
    fm_wdata  = '0;
    dm_we     = 1'b0;
    dm_waddr  = idx_q;
    dm_wdata  = '{visited: 1'b0, path: mfgd_pkg::DIST_INF};
    fm_raddr  = cur_q;
    dm_raddr  = idx_q;
    wt_start  = 1'b0;
    out_set   = 1'b0;
    out_d     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d.out_face = in_data_i.face_id;
          if (in_data_i.cmd != mfgd_pkg::CMD_NOP && id_bad) begin
            out_d.status = 1'b1;
            out_set      = 1'b1;
          end else begin
            case (in_data_i.cmd)
              mfgd_pkg::CMD_LOAD: begin
                fm_we = 1'b1;
                fm_wdata.geom = '{bary_x: in_data_i.bary_x, bary_y: in_data_i.bary_y,
                                  bary_z: in_data_i.bary_z, norm_x: in_data_i.norm_x,
                                  norm_y: in_data_i.norm_y, norm_z: in_data_i.norm_z};
                fm_wdata.nbr[0] = '{valid: in_data_i.nbr_count > 2'd0, id: in_data_i.nbr_a};
                fm_wdata.nbr[1] = '{valid: in_data_i.nbr_count > 2'd1, id: in_data_i.nbr_b};
                fm_wdata.nbr[2] = '{valid: in_data_i.nbr_count > 2'd2, id: in_data_i.nbr_c};
                out_set = 1'b1;
              end
              mfgd_pkg::CMD_RUN: begin
                start_d   = in_data_i.face_id;
                face_id_d = in_data_i.face_id;
                run_d     = 1'b1;
                idx_d     = '0;
                state_d   = S_CLEAR;
              end
              mfgd_pkg::CMD_READ: begin
                dm_raddr  = in_data_i.face_id;
                face_id_d = in_data_i.face_id;
                state_d   = S_READ;
              end
              default: out_set = 1'b1;
            endcase
          end
        end
      end
      S_CLEAR: begin
        dm_we = 1'b1;
        idx_d = idx_q + FW'(1);
        if (idx_q == FW'(mfgd_pkg::MAX_FACES - 1)) state_d = run_q ? S_START : S_IDLE;
      end
      S_START: begin
        dm_we     = 1'b1;
        dm_waddr  = start_q;
        dm_wdata  = '{visited: 1'b0, path: '0};
        reached_d = '0;
        idx_d     = '0;
        found_d   = 1'b0;
        run_d     = 1'b0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        found_d = found_n;
        best_d  = best_n;
        cur_d   = cur_n;
        rv_d    = 1'b1;
        if ({1'b0, idx_q} == fc_m1) state_d = S_SCEND;
        else idx_d = idx_q + FW'(1);
      end
      S_SCEND: begin
        found_d = found_n;
        best_d  = best_n;
        cur_d   = cur_n;
        if (found_n) begin
          state_d = S_VISIT;
        end else begin
          out_set             = 1'b1;
          out_d.out_face      = face_id_q;
          out_d.reached_count = reached_q;
          state_d             = S_IDLE;
        end
      end
      S_VISIT: begin
        dm_we     = 1'b1;
        dm_waddr  = cur_q;
        dm_wdata  = '{visited: 1'b1, path: best_q};
        fm_raddr  = cur_q;
        reached_d = reached_q + CW'(1);
        state_d   = S_UREC;
      end
      S_UREC: begin
        k_d     = '0;
        state_d = S_NBR;
      end
      S_NBR: begin
        if (cur_nbr.valid && ({1'b0, cur_nbr.id} < fc)) begin
          fm_raddr = cur_nbr.id;
          dm_raddr = cur_nbr.id;
          nb_d     = cur_nbr.id;
          state_d  = S_VREC;
        end else if (last_nbr) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_VREC: state_d = S_WGO;
      S_WGO: begin
        wt_start = 1'b1;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (wt_rsp.done) begin
          if (nd < dnb_q.path) begin
            dm_we    = 1'b1;
            dm_waddr = nb_q;
            dm_wdata = '{visited: dnb_q.visited, path: nd};
          end
          if (last_nbr) begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_NBR;
          end
        end
      end
      S_READ: begin
        out_set        = 1'b1;
        out_d.out_face = face_id_q;
        out_d.distance = dist_rdata_q.path;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      run_q       <= 1'b0;
      reached_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rv_q      <= rv_d;
      found_q   <= found_d;
      run_q     <= run_d;
      reached_q <= reached_d;
      k_q       <= k_d;
      if (out_set) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q    <= idx_q;
    best_q    <= best_d;
    cur_q     <= cur_d;
    start_q   <= start_d;
    nb_q      <= nb_d;
    face_id_q <= face_id_d;
    if (out_set) out_q <= out_d;
    if (state_q == S_UREC) begin
      u_geom_q <= face_rdata_q.geom;
      u_nbr_q  <= face_rdata_q.nbr;
    end
    if (state_q == S_VREC) begin
      v_geom_q <= face_rdata_q.geom;
      dnb_q    <= dist_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) face_mem[in_data_i.face_id] <= fm_wdata;
    face_rdata_q <= face_mem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dist_mem[dm_waddr] <= dm_wdata;
    dist_rdata_q <= dist_mem[dm_raddr];
  end

  mfgd_weight u_weight (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (wt_start),
    .u_i          (u_geom_q),
    .v_i          (v_geom_q),
    .edge_scale_i (edge_scale_q),
    .rsp_o        (wt_rsp)
  );

`ifndef SYNTH
  a_reached_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_NBR) |-> reached_q <= fc)
    else $error("reached count exceeds faces in use");
  a_visit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_VISIT |=> reached_q == $past(reached_q) + CW'(1))
    else $error("visit did not count a reached face");
  a_visit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_VISIT |-> found_q && best_q != mfgd_pkg::DIST_INF)
    else $error("visit without a reachable face");
  a_weight_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WGO |=> state_q == S_WAIT && !wt_rsp.done)
    else $error("weight unit answered too early");
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status |-> out_q.distance == '0 && out_q.reached_count == '0)
    else $error("error beat carries data");
`endif

endmodule

// ===== bench/mfgd_checker.sv =====
`timescale 1ns / 1ps
// Checker for the geodesic engine: predicts each result beat and compares it.
module mfgd_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  mfgd_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  mfgd_pkg::out_item_t out_data_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam logic [31:0] ONES = 32'hffff_ffff;
  localparam int NF = mfgd_pkg::MAX_FACES;
  localparam int NN = mfgd_pkg::MAX_NEIGHBORS;

  logic [31:0] scale_q;
  logic [10:0] count_q;
  logic [31:0] bx [NF];
  logic [31:0] by [NF];
  logic [31:0] bz [NF];
  logic [31:0] nx [NF];
  logic [31:0] ny [NF];
  logic [31:0] nz [NF];
  logic        link_ok [NF][NN];
  logic [9:0]  link_id [NF][NN];
  logic [31:0] path_len [NF];
  logic        settled [NF];
  mfgd_pkg::out_item_t expected_q [$];
  int          errors;

  assign pending_o = expected_q.size();
  assign errors_o  = errors;

  function automatic int faces_active();
    return (count_q == 0 || count_q > NF) ? NF : int'(count_q);
  endfunction

  function automatic logic [31:0] root64(input logic [63:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if ({32'd0, t} * {32'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ONES : s[31:0];
  endfunction

  function automatic logic [63:0] diff_sq(input logic [31:0] a, input logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return 64'(d) * 64'(d);
  endfunction

  function automatic logic [31:0] chord(input int u, input int v);
    logic [65:0] s;
    s = {2'b0, diff_sq(bx[u], bx[v])} + {2'b0, diff_sq(by[u], by[v])}
        + {2'b0, diff_sq(bz[u], bz[v])};
    return (s[65:64] != 0) ? ONES : root64(s[63:0]);
  endfunction

  // Shrinks a normal so every component magnitude is below 2^14.
  function automatic void shrink(input logic [31:0] rx, input logic [31:0] ry,
                                 input logic [31:0] rz, output longint c[3]);
    longint mag [3];
    longint m;
    int     sh;
    mag[0] = longint'($signed(rx));
    mag[1] = longint'($signed(ry));
    mag[2] = longint'($signed(rz));
    m = 0;
    for (int i = 0; i < 3; i++) begin
      if (mag[i] < 0) mag[i] = -mag[i];
      if (mag[i] > m) m = mag[i];
    end
    sh = 0;
    while ((m >> sh) >= (64'd1 << mfgd_pkg::NORM_LIMIT_BITS)) sh++;
    c[0] = rx[31] ? -(mag[0] >> sh) : (mag[0] >> sh);
    c[1] = ry[31] ? -(mag[1] >> sh) : (mag[1] >> sh);
    c[2] = rz[31] ? -(mag[2] >> sh) : (mag[2] >> sh);
  endfunction

  function automatic logic [31:0] bend(input int u, input int v);
    longint      a [3];
    longint      b [3];
    longint      cx, cy, cz, p;
    logic [63:0] c;
    logic [95:0] q;
    logic [63:0] prod;
    shrink(nx[u], ny[u], nz[u], a);
    shrink(nx[v], ny[v], nz[v], b);
    cx = a[1] * b[2] - a[2] * b[1];
    cy = a[2] * b[0] - a[0] * b[2];
    cz = a[0] * b[1] - a[1] * b[0];
    c  = 64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz);
    p  = (a[0] * a[0] + a[1] * a[1] + a[2] * a[2]) * (b[0] * b[0] + b[1] * b[1] + b[2] * b[2]);
    if (p == 0) return '0;
    q = {c, 32'd0} / {32'd0, 64'(p)};
    prod = {32'd0, root64(q[63:0])} * {32'd0, scale_q};
    return prod[47:16];
  endfunction

  // Shortest paths from one face, lowest index wins a tie.
  function automatic logic [10:0] spread_from(input int start, input int fc);
    int          reached;
    int          cur;
    logic [31:0] best;
    logic [31:0] nd;
    bit          found;
    for (int i = 0; i < NF; i++) begin
      path_len[i] = ONES;
      settled[i]  = 1'b0;
    end
    path_len[start] = '0;
    reached = 0;
    forever begin
      found = 0;
      best  = ONES;
      cur   = 0;
      for (int i = 0; i < fc; i++) begin
        if (!settled[i] && path_len[i] != ONES && (!found || path_len[i] < best)) begin
          best  = path_len[i];
          cur   = i;
          found = 1;
        end
      end
      if (!found) break;
      settled[cur] = 1'b1;
      reached++;
      for (int k = 0; k < NN; k++) begin
        if (link_ok[cur][k] && int'(link_id[cur][k]) < fc) begin
          nd = add_sat(best, add_sat(chord(cur, link_id[cur][k]), bend(cur, link_id[cur][k])));
          if (nd < path_len[link_id[cur][k]]) path_len[link_id[cur][k]] = nd;
        end
      end
    end
    return 11'(reached);
  endfunction

  function automatic mfgd_pkg::out_item_t predict(input mfgd_pkg::in_item_t it);
    mfgd_pkg::out_item_t r;
    int        fc;
    int        id;
    fc = faces_active();
    id = int'(it.face_id);
    r  = '0;
    r.out_face = it.face_id;
    if (mfgd_pkg::cmd_e'(it.cmd) != mfgd_pkg::CMD_NOP && id >= fc) begin
      r.status = 1'b1;
    end else begin
      case (mfgd_pkg::cmd_e'(it.cmd))
        mfgd_pkg::CMD_LOAD: begin
          bx[id] = it.bary_x;
          by[id] = it.bary_y;
          bz[id] = it.bary_z;
          nx[id] = it.norm_x;
          ny[id] = it.norm_y;
          nz[id] = it.norm_z;
          link_id[id][0] = it.nbr_a;
          link_id[id][1] = it.nbr_b;
          link_id[id][2] = it.nbr_c;
          for (int k = 0; k < NN; k++) link_ok[id][k] = (k < it.nbr_count);
        end
        mfgd_pkg::CMD_RUN:  r.reached_count = spread_from(id, fc);
        mfgd_pkg::CMD_READ: r.distance = path_len[id];
        default: ;
      endcase
    end
    return r;
  endfunction

  initial begin
    errors = 0;
    for (int i = 0; i < NF; i++) begin
      path_len[i] = ONES;
      settled[i]  = 1'b0;
      bx[i] = '0; by[i] = '0; bz[i] = '0;
      nx[i] = '0; ny[i] = '0; nz[i] = '0;
      for (int k = 0; k < NN; k++) begin
        link_ok[i][k] = 1'b0;
        link_id[i][k] = '0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      count_q <= 11'd1024;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mfgd_pkg::CFG_EDGE_SCALE) scale_q <= cfg_wdata_i;
      else count_q <= cfg_wdata_i[10:0];
    end
  end

  always @(posedge clk_i) begin
    mfgd_pkg::out_item_t e;
    if (rst_ni && in_valid_i && in_ready_i) expected_q = {expected_q, predict(in_data_i)};
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_data_i);
      end else begin
        e = expected_q.pop_front();
        if (e.status !== out_data_i.status || e.out_face !== out_data_i.out_face ||
            e.distance !== out_data_i.distance ||
            e.reached_count !== out_data_i.reached_count) begin
          errors++;
          if (errors <= 10)
            $display({"result mismatch: expected st=%0d face=%0d dist=%h reached=%0d,",
                      " got st=%0d face=%0d dist=%h reached=%0d"},
                     e.status, e.out_face, e.distance, e.reached_count,
                     out_data_i.status, out_data_i.out_face, out_data_i.distance,
                     out_data_i.reached_count);
        end
      end
    end
  end

endmodule

// ===== bench/mesh_face_geodesic_dijkstra_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives loads, runs and reads through phases of configuration.
module mesh_face_geodesic_dijkstra_tb;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we;
  logic      cfg_idx;
  logic [31:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  mfgd_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  mfgd_pkg::out_item_t out_data;
  int        pending;
  int        errors;
  int        sent;
  int        cycles = 0;

  mesh_face_geodesic_dijkstra dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  mfgd_checker u_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return '0;
      default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [31:0] ncomp();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return '0;
      default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  task automatic send(input mfgd_pkg::in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic face_load(input int id, input int hi, input bit far);
    mfgd_pkg::in_item_t it;
    logic [9:0] ids [3];
    it = '0;
    it.cmd = mfgd_pkg::CMD_LOAD;
    it.face_id = 10'(id);
    it.bary_x = coord();
    it.bary_y = coord();
    it.bary_z = coord();
    if ($urandom_range(0, 7) != 0) begin
      it.norm_x = ncomp();
      it.norm_y = ncomp();
      it.norm_z = ncomp();
    end
    for (int k = 0; k < 3; k++)
      ids[k] = (far && $urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, hi));
    it.nbr_a = ids[0];
    it.nbr_b = ids[1];
    it.nbr_c = ids[2];
    it.nbr_count = 2'($urandom_range(0, 3));
    send(it);
  endtask

  task automatic simple(input mfgd_pkg::cmd_e c, input int id);
    mfgd_pkg::in_item_t it;
    it = '0;
    it.cmd = c;
    it.face_id = 10'(id);
    // Fields that the command ignores still carry noise.
    it.bary_x = $urandom;
    it.norm_z = $urandom;
    it.nbr_count = 2'($urandom_range(0, 3));
    send(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Faces below closed link in range only to each other, so runs stay on loaded records.
  task automatic phase(input logic [31:0] fc, input logic [31:0] scale, input int closed,
                       input int run_pct, input int n);
    int  r;
    bit  small_mesh;
    settle();
    reg_write(mfgd_pkg::CFG_FACE_COUNT, fc);
    reg_write(mfgd_pkg::CFG_EDGE_SCALE, scale);
    small_mesh = (closed < 1024 && fc != 0 && fc <= 1024 && closed == int'(fc));
    for (int i = 0; i < closed; i++) face_load(i, closed - 1, small_mesh);
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < run_pct) simple(mfgd_pkg::CMD_RUN, $urandom_range(0, closed - 1));
      else if (r < run_pct + 3) simple(mfgd_pkg::CMD_NOP, $urandom);
      else if (r < 50) begin
        if (small_mesh && $urandom_range(0, 4) == 0) simple(mfgd_pkg::CMD_READ, $urandom);
        else simple(mfgd_pkg::CMD_READ, $urandom_range(0, closed - 1));
      end else if (r < 55) begin
        if (small_mesh) simple(mfgd_pkg::CMD_RUN, $urandom_range(closed, 1023));
        else face_load($urandom_range(closed, 1023), 1023, 1'b1);
      end else begin
        if (small_mesh && $urandom_range(0, 5) == 0) face_load($urandom, 1023, 1'b1);
        else face_load($urandom_range(0, closed - 1), closed - 1, small_mesh);
      end
    end
  endtask

  task automatic directed();
    mfgd_pkg::in_item_t it;
    reg_write(mfgd_pkg::CFG_FACE_COUNT, 32'd4);
    reg_write(mfgd_pkg::CFG_EDGE_SCALE, 32'h0001_0000);
    it = '0;
    it.cmd = mfgd_pkg::CMD_LOAD;
    it.bary_x = 32'h7fff_ffff; it.bary_y = 32'h7fff_ffff; it.bary_z = 32'h7fff_ffff;
    it.nbr_a = 10'd1; it.nbr_b = 10'd2; it.nbr_c = 10'd1023; it.nbr_count = 2'd3;
    send(it);
    it.face_id = 10'd1;
    it.bary_x = 32'h8000_0000; it.bary_y = 32'h8000_0000; it.bary_z = 32'h8000_0000;
    it.norm_x = 32'h8000_0000; it.norm_y = 32'h7fff_ffff; it.norm_z = 32'hffff_ffff;
    it.nbr_a = 10'd0; it.nbr_count = 2'd1;
    send(it);
    it.face_id = 10'd2;
    it.bary_x = 32'h0001_0000; it.bary_y = '0; it.bary_z = 32'hffff_0000;
    it.norm_x = 32'h0001_0000; it.norm_y = '0; it.norm_z = '0;
    it.nbr_a = 10'd3; it.nbr_b = 10'd0; it.nbr_count = 2'd2;
    send(it);
    it.face_id = 10'd3;
    it.bary_x = 32'h0003_0000; it.bary_y = 32'h0004_0000; it.bary_z = 32'hffff_0000;
    it.norm_x = '0; it.norm_y = 32'h0001_0000; it.norm_z = '0;
    it.nbr_a = 10'd2; it.nbr_count = 2'd0;
    send(it);
    simple(mfgd_pkg::CMD_RUN, 0);
    for (int i = 0; i < 4; i++) simple(mfgd_pkg::CMD_READ, i);
    simple(mfgd_pkg::CMD_READ, 1023);
    simple(mfgd_pkg::CMD_RUN, 1023);
    simple(mfgd_pkg::CMD_NOP, 1023);
    it.face_id = 10'd1023;
    send(it);
    simple(mfgd_pkg::CMD_RUN, 2);
    for (int i = 0; i < 4; i++) simple(mfgd_pkg::CMD_READ, i);
    simple(mfgd_pkg::CMD_RUN, 1);
    simple(mfgd_pkg::CMD_READ, 0);
  endtask

  // Result side: one long hold early on, then random stalls and open stretches.
  initial begin
    int r;
    bit held;
    out_ready <= 1'b0;
    held = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && sent >= 40) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else if (r < 65) begin
        out_ready <= 1'b1;
        repeat (100) @(posedge clk_i);
      end else begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    sent       = 0;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= mfgd_pkg::CFG_EDGE_SCALE;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    directed();
    phase(32'd1,    32'd0,         1,  10, 50);
    phase(32'd2047, 32'hffff_ffff, 8,  2,  90);
    phase(32'd5,    32'h0001_0000, 5,  8,  130);
    phase(32'd16,   $urandom,      16, 6,  170);
    phase(32'd1024, 32'h0000_8000, 8,  2,  90);
    phase(32'd0,    32'd0,         8,  2,  60);
    phase(32'd24,   $urandom,      24, 5,  170);
    phase(32'd40,   32'h0004_0000, 40, 3,  170);
    phase(32'd3,    32'hffff_ffff, 3,  10, 110);
    phase(32'd12,   $urandom,      12, 6,  200);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
